[hdl/beam_steering_phase_codes_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the beam steering phase code block
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BEAM_STEERING_PHASE_CODES_ASSERT_SVH
`define BEAM_STEERING_PHASE_CODES_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define BSPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// expression must never be true out of reset
`define BSPC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define BSPC_ASSERT(label, prop, msg)
`define BSPC_NEVER(label, expr, msg)
`endif
`endif

[hdl/bspc_pkg.sv]
// ----------------------------------------------------------------------------
// bspc_pkg
// Shared constants, types and the 0 to 45 degree sine table for the phase
// code generator.
// ----------------------------------------------------------------------------
package bspc_pkg;

  // array geometry and code width
  localparam int ARRAY_COLS = 4;
  localparam int ELEMENTS   = 16;
  localparam int CODE_BITS  = 6;
  localparam int ROWS       = ELEMENTS / ARRAY_COLS;

  // port widths fixed by the field definitions
  localparam int ANGLE_W   = 12;
  localparam int ELEMENT_W = 4;
  localparam int CODE_W    = 6;

  // angle clamp and sine format
  localparam int ANGLE_LIMIT  = 720;
  localparam int MAG_W        = $clog2(ANGLE_LIMIT + 1);
  localparam int SIN_W        = 15;
  localparam int SINE_W       = SIN_W + 1;
  localparam int FRAC_BITS    = 15;
  localparam int SERIES_TERMS = 12;
  localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C234;
  localparam int          FULL_TURN_16 = 2880;
  localparam logic [63:0] SIN_STEP     = PI_Q62 / 64'(FULL_TURN_16);

  // queue depth, shared by the request queue and the result buffer
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // back end arithmetic widths
  localparam int EL_W     = $clog2(ELEMENTS);
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W    = (ARRAY_COLS > 1) ? $clog2(ARRAY_COLS) : 1;
  localparam int MAX_DIM  = (ROWS > ARRAY_COLS) ? ROWS : ARRAY_COLS;
  localparam int WEIGHT_W = $clog2(MAX_DIM) + 2;
  localparam int PROD_W   = SINE_W + WEIGHT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SCALED_W = SUM_W + CODE_BITS - 2;
  localparam int HALF_LSB = 1 << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [SINE_W-1:0] s_az;
    logic signed [SINE_W-1:0] s_el;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                 chain;
    logic [ELEMENT_W-1:0] element;
    logic                 last;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [CODE_W-1:0] code;
  } result_t;

  typedef logic [SIN_W-1:0] sin_tab_t [ANGLE_LIMIT+1];

  // (a * b) >> 62
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // unsigned quotient by shift and subtract; only used while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(32768 * sin(a / 16 degrees)) for 0 <= a <= ANGLE_LIMIT, by series
  function automatic sin_tab_t bspc_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    for (int a = 0; a <= ANGLE_LIMIT; a++) begin
      x    = SIN_STEP * 64'(a);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        den  = 64'((2 * n) * (2 * n + 1));
        term = udiv64(mul_q62(term, x2), den);
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      tab[a] = SIN_W'((sum + (64'd1 << 46)) >> 47);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = bspc_sin_tab();

endpackage

[hdl/beam_steering_phase_codes.sv]
// ----------------------------------------------------------------------------
// beam_steering_phase_codes
// Phase shifter codes for a planar array from an azimuth/elevation request.
//
//   channel   direction  handshake            payload
//   request   in         push / full          az_angle_i, el_angle_i
//   codes     out        empty / pop          chain_o, element_o, code_o, last_o
//
// Each request yields 2*ELEMENTS codes (32), one per clock while pop keeps
// up; the sequencer's single multiply stage produces one code per cycle
// while the result buffer has room.
// A request passes the front register, queue, product stage and result buffer.
// No clearing pass after reset; the sine table is a constant ROM.
// With pop low the result buffer fills and the sequencer holds; two sine
// pairs wait in the queue and one more in the front register, then full rises.
// ----------------------------------------------------------------------------
module beam_steering_phase_codes (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [bspc_pkg::ANGLE_W-1:0]  az_angle_i,
  input  logic signed [bspc_pkg::ANGLE_W-1:0]  el_angle_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 chain_o,
  output logic [bspc_pkg::ELEMENT_W-1:0]       element_o,
  output logic [bspc_pkg::CODE_W-1:0]          code_o,
  output logic                                 last_o
);
  import bspc_pkg::*;

  push_t   fe_push;
  q_stat_t q_stat;
  pair_t   q_head;
  logic    q_pop;

  bspc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .az_angle_i (az_angle_i),
    .el_angle_i (el_angle_i),
    .full_o     (full),
    .q_stat_i   (q_stat),
    .push_o     (fe_push)
  );

  bspc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fe_push),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  bspc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .head_i    (q_head),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .chain_o   (chain_o),
    .element_o (element_o),
    .code_o    (code_o),
    .last_o    (last_o)
  );

endmodule

[hdl/bspc_queue.sv]
// ----------------------------------------------------------------------------
// bspc_queue
// Short queue of sine pairs between the front end and the code sequencer.
// ----------------------------------------------------------------------------
`include "beam_steering_phase_codes_assert.svh"

module bspc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bspc_pkg::push_t   wr_i,
  input  logic              pop_i,
  output bspc_pkg::pair_t   head_o,
  output bspc_pkg::q_stat_t stat_o
);
  import bspc_pkg::*;

  pair_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign do_wr = wr_i.valid && !stat_o.full;
  assign do_rd = pop_i && !stat_o.empty;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.pair;
    end
  end

  `BSPC_NEVER(a_q_over, cnt_q > QCNT_W'(QUEUE_DEPTH), "queue count beyond its depth")
  `BSPC_NEVER(a_q_rd_empty, pop_i && stat_o.empty, "request taken from an empty queue")

endmodule

[hdl/bspc_front.sv]
// ----------------------------------------------------------------------------
// bspc_front
// Accepts steering requests, clamps both angles and looks up their sines.
// ----------------------------------------------------------------------------
`include "beam_steering_phase_codes_assert.svh"

module bspc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  logic signed [bspc_pkg::ANGLE_W-1:0] az_angle_i,
  input  logic signed [bspc_pkg::ANGLE_W-1:0] el_angle_i,
  output logic                               full_o,
  input  bspc_pkg::q_stat_t                  q_stat_i,
  output bspc_pkg::push_t                    push_o
);
  import bspc_pkg::*;

  logic             s_valid_q, s_valid_d;
  logic [SIN_W-1:0] sin_az_q, sin_el_q;
  logic             neg_az_q, neg_el_q;
  logic             accept, drain;
  logic [MAG_W-1:0] mag_az, mag_el;

  // absolute value, clamped to the angle limit
  function automatic logic [MAG_W-1:0] angle_mag(logic signed [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] m;
    m = a[ANGLE_W-1] ? ANGLE_W'(-a) : ANGLE_W'(a);
    if (m > ANGLE_W'(ANGLE_LIMIT)) begin
      m = ANGLE_W'(ANGLE_LIMIT);
    end
    return MAG_W'(m);
  endfunction

  assign mag_az = angle_mag(az_angle_i);
  assign mag_el = angle_mag(el_angle_i);

  assign full_o = s_valid_q && q_stat_i.full;
  assign accept = push_i && !full_o;
  assign drain  = s_valid_q && !q_stat_i.full;

  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (drain) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  // sine ROM, registered read; hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sin_az_q <= SIN_TAB[mag_az];
      sin_el_q <= SIN_TAB[mag_el];
      neg_az_q <= az_angle_i[ANGLE_W-1];
      neg_el_q <= el_angle_i[ANGLE_W-1];
    end
  end

  assign push_o.valid       = s_valid_q;
  assign push_o.pair.s_az   = neg_az_q ? -$signed({1'b0, sin_az_q}) : $signed({1'b0, sin_az_q});
  assign push_o.pair.s_el   = neg_el_q ? -$signed({1'b0, sin_el_q}) : $signed({1'b0, sin_el_q});

  `BSPC_ASSERT(a_fe_take, push_i && !full_o |=> s_valid_q, "accepted request not held")

endmodule

[hdl/bspc_back.sv]
// ----------------------------------------------------------------------------
// bspc_back
// Walks both chains over all elements, one phase code per cycle while the
// result buffer has room, into a two-entry result buffer.
// ----------------------------------------------------------------------------
`include "beam_steering_phase_codes_assert.svh"

module bspc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bspc_pkg::q_stat_t                   q_stat_i,
  input  bspc_pkg::pair_t                     head_i,
  output logic                                q_pop_o,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic                                chain_o,
  output logic [bspc_pkg::ELEMENT_W-1:0]      element_o,
  output logic [bspc_pkg::CODE_W-1:0]         code_o,
  output logic                                last_o
);
  import bspc_pkg::*;

  // sequencer
  logic             chain_q;
  logic [EL_W-1:0]  elem_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             advance, issue, is_last;

  // product stage
  logic                     s1_valid_q;
  logic signed [PROD_W-1:0] p_az_q, p_el_q, p_az_d, p_el_d;
  tag_t                     tag_q, tag_d;
  logic signed [WEIGHT_W-1:0] w_row, w_col;

  // rounding stage
  logic signed [SUM_W-1:0]    v_sum;
  logic signed [SCALED_W-1:0] scaled;
  logic [CODE_BITS-1:0]       code_full;
  result_t                    res;

  // result buffer
  result_t           ob_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] ob_wr_q, ob_rd_q;
  logic [QCNT_W-1:0] ob_cnt_q;
  logic              ob_full, ob_wr, ob_rd;

  assign ob_full = (ob_cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (ob_cnt_q == '0);
  assign advance = !ob_full;
  assign issue   = advance && !q_stat_i.empty;
  assign is_last = chain_q && (elem_q == '0);
  assign q_pop_o = issue && is_last;

  assign w_row = $signed(WEIGHT_W'({row_q, 1'b0})) - $signed(WEIGHT_W'(ROWS - 1));
  assign w_col = $signed(WEIGHT_W'({col_q, 1'b0})) - $signed(WEIGHT_W'(ARRAY_COLS - 1));

  assign p_az_d = PROD_W'(w_row) * PROD_W'(head_i.s_az);
  assign p_el_d = PROD_W'(w_col) * PROD_W'(head_i.s_el);

  assign tag_d.chain   = chain_q;
  assign tag_d.element = ELEMENT_W'(elem_q);
  assign tag_d.last    = is_last;

  // step elements down, column fastest; transmit chain then receive chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= 1'b0;
      elem_q  <= EL_W'(ELEMENTS - 1);
      row_q   <= ROW_W'(ROWS - 1);
      col_q   <= COL_W'(ARRAY_COLS - 1);
    end else if (issue) begin
      if (elem_q == '0) begin
        chain_q <= !chain_q;
        elem_q  <= EL_W'(ELEMENTS - 1);
        row_q   <= ROW_W'(ROWS - 1);
        col_q   <= COL_W'(ARRAY_COLS - 1);
      end else begin
        elem_q <= elem_q - 1'b1;
        if (col_q == '0) begin
          col_q <= COL_W'(ARRAY_COLS - 1);
          row_q <= row_q - 1'b1;
        end else begin
          col_q <= col_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_az_q <= p_az_d;
      p_el_q <= p_el_d;
      tag_q  <= tag_d;
    end
  end

  // round to nearest code step, wrap modulo the code range
  assign v_sum     = SUM_W'(p_az_q) + SUM_W'(p_el_q);
  assign scaled    = (SCALED_W'(v_sum) <<< (CODE_BITS - 2)) + SCALED_W'(HALF_LSB);
  assign code_full = scaled[FRAC_BITS +: CODE_BITS];
  assign res.tag   = tag_q;
  assign res.code  = CODE_W'(code_full);

  assign ob_wr = s1_valid_q && advance;
  assign ob_rd = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= '0;
      ob_rd_q  <= '0;
      ob_cnt_q <= '0;
    end else begin
      if (ob_wr) begin
        ob_wr_q <= (ob_wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ob_wr_q + 1'b1;
      end
      if (ob_rd) begin
        ob_rd_q <= (ob_rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ob_rd_q + 1'b1;
      end
      if (ob_wr && !ob_rd) begin
        ob_cnt_q <= ob_cnt_q + 1'b1;
      end else if (ob_rd && !ob_wr) begin
        ob_cnt_q <= ob_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_wr) begin
      ob_q[ob_wr_q] <= res;
    end
  end

  assign chain_o   = ob_q[ob_rd_q].tag.chain;
  assign element_o = ob_q[ob_rd_q].tag.element;
  assign last_o    = ob_q[ob_rd_q].tag.last;
  assign code_o    = ob_q[ob_rd_q].code;

  `BSPC_ASSERT(a_be_pos, 32'(elem_q) == 32'(row_q) * ARRAY_COLS + 32'(col_q), "row and column out of step with element")
  `BSPC_NEVER(a_be_ob_over, ob_cnt_q > QCNT_W'(QUEUE_DEPTH), "result buffer overrun")
  `BSPC_ASSERT(a_be_last, !empty_o && last_o |-> chain_o && element_o == '0, "last flag on wrong result")

endmodule
